### rtl/core/arpresp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpresp_pkg
// Shared types, constants and byte-map helpers of the ARP request responder.
// ----------------------------------------------------------------------------
package arpresp_pkg;

	localparam int HdrLen   = 42;
	localparam int HdrAddrW = $clog2(HdrLen);
	localparam int MacBytes = 6;
	localparam int IpBytes  = 4;
	localparam int CheckLen = MacBytes + IpBytes;
	localparam int CheckW   = $clog2(CheckLen);
	localparam int CfgIdxW  = 2;
	localparam int CfgDataW = 48;

	// Register indexes of the configuration port
	localparam logic [CfgIdxW-1:0] REG_STATION_MAC = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_STATION_IP  = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_ENABLE      = 2'd2;

	// Fixed header bytes of an ARP request over Ethernet / IPv4
	localparam logic [7:0] EthTypeHi   = 8'h08;
	localparam logic [7:0] EthTypeLo   = 8'h06;
	localparam logic [7:0] HwTypeHi    = 8'h00;
	localparam logic [7:0] HwTypeLo    = 8'h01;
	localparam logic [7:0] ProtoTypeHi = 8'h08;
	localparam logic [7:0] ProtoTypeLo = 8'h00;
	localparam logic [7:0] OpcodeHi    = 8'h00;
	localparam logic [7:0] OpReqLo     = 8'h01;
	localparam logic [7:0] OpReplyLo   = 8'h02;
	localparam logic [7:0] BcastByte   = 8'hff;

	// Header offsets of the first target IP byte in the received frame
	localparam logic [HdrAddrW-1:0] TpaOffset = HdrAddrW'(38);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_CHK_END,
		ST_DECIDE,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		SRC_MEM,
		SRC_MAC,
		SRC_IP,
		SRC_CONST
	} src_sel_t;

	// Where one reply byte comes from: header memory address, address byte
	// lane, or a fixed value.
	typedef struct packed {
		src_sel_t            sel;
		logic [HdrAddrW-1:0] addr;
		logic [7:0]          value;
	} reply_src_t;

	typedef struct packed {
		logic       check;
		logic [7:0] value;
	} hdr_rule_t;

	typedef struct packed {
		logic                we;
		logic [HdrAddrW-1:0] waddr;
		logic [7:0]          wdata;
		logic [HdrAddrW-1:0] raddr;
	} ram_ctrl_t;

	function automatic hdr_rule_t hdr_rule(input logic [HdrAddrW-1:0] idx);
		hdr_rule_t r;
		r.check = 1'b1;
		r.value = 8'h00;
		case (idx)
			HdrAddrW'(12): r.value = EthTypeHi;
			HdrAddrW'(13): r.value = EthTypeLo;
			HdrAddrW'(14): r.value = HwTypeHi;
			HdrAddrW'(15): r.value = HwTypeLo;
			HdrAddrW'(16): r.value = ProtoTypeHi;
			HdrAddrW'(17): r.value = ProtoTypeLo;
			HdrAddrW'(20): r.value = OpcodeHi;
			HdrAddrW'(21): r.value = OpReqLo;
			default:       r.check = 1'b0;
		endcase
		return r;
	endfunction

	function automatic reply_src_t reply_src(input logic [HdrAddrW-1:0] idx);
		reply_src_t s;
		s.sel   = SRC_MEM;
		s.addr  = idx;
		s.value = 8'h00;
		if (idx < HdrAddrW'(6)) begin
			s.addr = idx + HdrAddrW'(6);
		end else if (idx < HdrAddrW'(12)) begin
			s.sel  = SRC_MAC;
			s.addr = idx - HdrAddrW'(6);
		end else if (idx < HdrAddrW'(20)) begin
			s.addr = idx;
		end else if (idx == HdrAddrW'(20)) begin
			s.sel   = SRC_CONST;
			s.value = OpcodeHi;
		end else if (idx == HdrAddrW'(21)) begin
			s.sel   = SRC_CONST;
			s.value = OpReplyLo;
		end else if (idx < HdrAddrW'(28)) begin
			s.sel  = SRC_MAC;
			s.addr = idx - HdrAddrW'(22);
		end else if (idx < HdrAddrW'(32)) begin
			s.sel  = SRC_IP;
			s.addr = idx - HdrAddrW'(28);
		end else begin
			s.addr = idx - HdrAddrW'(10);
		end
		return s;
	endfunction

	function automatic logic [7:0] mac_byte(input logic [47:0] mac, input logic [2:0] lane);
		logic [7:0] b;
		case (lane)
			3'd0:    b = mac[47:40];
			3'd1:    b = mac[39:32];
			3'd2:    b = mac[31:24];
			3'd3:    b = mac[23:16];
			3'd4:    b = mac[15:8];
			default: b = mac[7:0];
		endcase
		return b;
	endfunction

	function automatic logic [7:0] ip_byte(input logic [31:0] ip, input logic [1:0] lane);
		logic [7:0] b;
		case (lane)
			2'd0:    b = ip[31:24];
			2'd1:    b = ip[23:16];
			2'd2:    b = ip[15:8];
			default: b = ip[7:0];
		endcase
		return b;
	endfunction

endpackage

### rtl/core/arpresp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpresp_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module arpresp_ram #(
	parameter int Width = 8,
	parameter int Depth = 42
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/core/arp_request_responder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_request_responder
// Stores the first 42 bytes of each received frame and answers an ARP
// request for the station IP with a 42-byte ARP reply.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake               Payload
// frame     in         start & !busy           frame_byte, frame_end
// reply     out        reply_valid             reply_byte, reply_last
// config    in         cfg_write               cfg_index, cfg_data
//
// Busy stays low while a frame streams in, so bytes may arrive back to back.
// On the last byte of a frame of at least 42 bytes whose fixed header fields
// match, busy rises: header RAM reads check the destination MAC and the target
// IP, the check-end and decide states settle the decision, then one reply
// byte per cycle is read from the RAM port and passes through the stage-1 and
// output registers, 42 in all. A matching frame holds busy until its last reply
// byte is out, a rejected one through the decide state. Reset clears control
// and configuration; the header RAM is not cleared. The receiver cannot stall.
// ----------------------------------------------------------------------------
module arp_request_responder (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [7:0]                           frame_byte,
	input  logic                                 frame_end,
	input  logic                                 cfg_write,
	input  logic [arpresp_pkg::CfgIdxW-1:0]      cfg_index,
	input  logic [arpresp_pkg::CfgDataW-1:0]     cfg_data,
	output logic                                 reply_valid,
	output logic [7:0]                           reply_byte,
	output logic                                 reply_last
);

	import arpresp_pkg::*;

	// Configuration registers
	logic [47:0] station_mac_q;
	logic [31:0] station_ip_q;
	logic        responder_enable_q;

	// Receive side
	logic [HdrAddrW-1:0] byte_count_q;
	logic                hdr_ok_q;
	logic                accept;
	logic                hdr_full;
	hdr_rule_t           rule;

	// Sequencer
	state_t              state_q, state_d;
	logic [CheckW-1:0]   chk_cnt_q;
	logic [HdrAddrW-1:0] emit_cnt_q;
	logic                to_me_q, to_all_q, tpa_ok_q;
	logic                reply_ok;
	reply_src_t          src;

	// Pipeline behind the RAM read
	logic                chk_valid_s1;
	logic [CheckW-1:0]   chk_idx_s1;
	logic                emit_valid_s1;
	logic                emit_last_s1;
	reply_src_t          emit_src_s1;

	// Output register
	logic                reply_valid_q;
	logic                reply_last_q;
	logic [7:0]          reply_byte_q;

	ram_ctrl_t           ram_ctrl;
	logic [7:0]          ram_rdata;
	logic [7:0]          chk_expect;

	// ------------------------------------------------------------------------
	// Configuration: indexes beyond the register list are dropped
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			station_mac_q      <= '0;
			station_ip_q       <= '0;
			responder_enable_q <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_STATION_MAC: station_mac_q      <= cfg_data[47:0];
				REG_STATION_IP:  station_ip_q       <= cfg_data[31:0];
				REG_ENABLE:      responder_enable_q <= cfg_data[0];
				default:         ;
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// Receive: store the header, track the fixed fields as they stream past
	// ------------------------------------------------------------------------
	assign accept   = start && !busy;
	assign hdr_full = (byte_count_q >= HdrAddrW'(HdrLen - 1));
	assign rule     = hdr_rule(byte_count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			hdr_ok_q     <= 1'b0;
		end else if (accept) begin
			if (frame_end) begin
				byte_count_q <= '0;
			end else if (byte_count_q < HdrAddrW'(HdrLen)) begin
				byte_count_q <= byte_count_q + HdrAddrW'(1);
			end
			// Re-arm on the first byte, drop on any fixed-field mismatch
			if (byte_count_q == '0) begin
				hdr_ok_q <= 1'b1;
			end else if (rule.check && (frame_byte != rule.value)) begin
				hdr_ok_q <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Header RAM: written while receiving, read while checking and replying
	// ------------------------------------------------------------------------
	assign src = reply_src(emit_cnt_q);

	always_comb begin
		ram_ctrl.we    = accept && (byte_count_q < HdrAddrW'(HdrLen));
		ram_ctrl.waddr = byte_count_q;
		ram_ctrl.wdata = frame_byte;
		if (state_q == ST_CHECK) begin
			// Destination MAC bytes first, then the target IP bytes
			if (chk_cnt_q < CheckW'(MacBytes)) begin
				ram_ctrl.raddr = HdrAddrW'(chk_cnt_q);
			end else begin
				ram_ctrl.raddr = HdrAddrW'(chk_cnt_q - CheckW'(MacBytes)) + TpaOffset;
			end
		end else begin
			ram_ctrl.raddr = src.addr;
		end
	end

	arpresp_ram #(
		.Width(8),
		.Depth(HdrLen)
	) u_hdr_ram (
		.clk   (clk),
		.we    (ram_ctrl.we),
		.waddr (ram_ctrl.waddr),
		.wdata (ram_ctrl.wdata),
		.raddr (ram_ctrl.raddr),
		.rdata (ram_rdata)
	);

	// ------------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------------
	assign reply_ok = responder_enable_q && (station_ip_q != '0) &&
	                  (to_me_q || to_all_q) && tpa_ok_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && frame_end && hdr_full && hdr_ok_q) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (chk_cnt_q == CheckW'(CheckLen - 1)) begin
					state_d = ST_CHK_END;
				end
			end
			ST_CHK_END: state_d = ST_DECIDE;
			ST_DECIDE:  state_d = reply_ok ? ST_EMIT : ST_IDLE;
			ST_EMIT: begin
				if (emit_cnt_q == HdrAddrW'(HdrLen - 1)) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Advance the check and emit counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chk_cnt_q  <= '0;
			emit_cnt_q <= '0;
		end else begin
			chk_cnt_q  <= (state_q == ST_CHECK) ? chk_cnt_q + CheckW'(1) : '0;
			emit_cnt_q <= (state_q == ST_EMIT) ? emit_cnt_q + HdrAddrW'(1) : '0;
		end
	end

	// ------------------------------------------------------------------------
	// Stage 1: RAM data is back; compare or pick the reply byte
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chk_valid_s1  <= 1'b0;
			emit_valid_s1 <= 1'b0;
		end else begin
			chk_valid_s1  <= (state_q == ST_CHECK);
			emit_valid_s1 <= (state_q == ST_EMIT);
		end
	end

	always_ff @(posedge clk) begin
		chk_idx_s1   <= chk_cnt_q;
		emit_src_s1  <= src;
		emit_last_s1 <= (emit_cnt_q == HdrAddrW'(HdrLen - 1));
	end

	always_comb begin
		if (chk_idx_s1 < CheckW'(MacBytes)) begin
			chk_expect = mac_byte(station_mac_q, 3'(chk_idx_s1));
		end else begin
			chk_expect = ip_byte(station_ip_q, 2'(chk_idx_s1 - CheckW'(MacBytes)));
		end
	end

	// Accumulate the address matches; arm them while idle, before the check starts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			to_me_q  <= 1'b0;
			to_all_q <= 1'b0;
			tpa_ok_q <= 1'b0;
		end else if (state_q == ST_IDLE) begin
			to_me_q  <= 1'b1;
			to_all_q <= 1'b1;
			tpa_ok_q <= 1'b1;
		end else if (chk_valid_s1) begin
			if (chk_idx_s1 < CheckW'(MacBytes)) begin
				if (ram_rdata != chk_expect) to_me_q  <= 1'b0;
				if (ram_rdata != BcastByte)  to_all_q <= 1'b0;
			end else if (ram_rdata != chk_expect) begin
				tpa_ok_q <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Output register
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reply_valid_q <= 1'b0;
			reply_last_q  <= 1'b0;
		end else begin
			reply_valid_q <= emit_valid_s1;
			reply_last_q  <= emit_valid_s1 && emit_last_s1;
		end
	end

	always_ff @(posedge clk) begin
		case (emit_src_s1.sel)
			SRC_MEM:   reply_byte_q <= ram_rdata;
			SRC_MAC:   reply_byte_q <= mac_byte(station_mac_q, 3'(emit_src_s1.addr));
			SRC_IP:    reply_byte_q <= ip_byte(station_ip_q, 2'(emit_src_s1.addr));
			SRC_CONST: reply_byte_q <= emit_src_s1.value;
			default:   reply_byte_q <= emit_src_s1.value;
		endcase
	end

	assign busy        = (state_q != ST_IDLE) || emit_valid_s1 || reply_valid_q;
	assign reply_valid = reply_valid_q;
	assign reply_last  = reply_last_q;
	assign reply_byte  = reply_byte_q;

	// ------------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------------
`ifndef SYNTHESIS
	a_reply_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		reply_valid |-> busy)
		else $error("reply byte outside a busy window");

	a_reply_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		reply_valid |-> $past(state_q == ST_EMIT, 2))
		else $error("reply byte not issued by the emit sequence");

	a_last_ends_reply: assert property (@(posedge clk) disable iff (!arst_n)
		reply_last |=> !reply_valid && !busy)
		else $error("reply continues after its last byte");

	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !ram_ctrl.we)
		else $error("header RAM written while checking or replying");
`endif

endmodule

### test/arp_reply_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_reply_checker
// Watches the frame, configuration and reply channels of the ARP responder,
// predicts every reply byte from the accepted frame bytes and compares.
// ----------------------------------------------------------------------------
module arp_reply_checker
	import arpresp_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                busy,
	input  logic [7:0]          frame_byte,
	input  logic                frame_end,
	input  logic                cfg_write,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	input  logic                reply_valid,
	input  logic [7:0]          reply_byte,
	input  logic                reply_last,
	output int                  mismatches,
	output int                  awaited,
	output int                  replies_checked
);

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} reply_beat_t;

	logic [7:0]  rx_hdr [HdrLen];
	int          rx_fill;
	logic [47:0] own_mac;
	logic [31:0] own_ip;
	logic        answer_on;
	reply_beat_t reply_q [$];
	int          err_n  = 0;
	int          seen_n = 0;

	function automatic logic [7:0] own_mac_byte(input int lane);
		return own_mac[47-8*lane -: 8];
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		logic [7:0]  ans [HdrLen];
		reply_beat_t want;
		logic        to_me, to_all, hit;
		int          i;
		if (!arst_n) begin
			rx_fill   = 0;
			own_mac   = '0;
			own_ip    = '0;
			answer_on = 1'b0;
			reply_q.delete();
			awaited <= 0;
		end else begin
			// compare first, so a reply with nothing queued is always flagged
			if (reply_valid !== 1'b0) begin
				seen_n++;
				if (reply_q.size() == 0) begin
					err_n++;
					$display("%0t: reply byte: expected none, actual %02h last %0b",
						$time, reply_byte, reply_last);
				end else begin
					want = reply_q.pop_front();
					if (reply_byte !== want.data) begin
						err_n++;
						$display("%0t: reply_byte: expected %02h, actual %02h",
							$time, want.data, reply_byte);
					end
					if (reply_last !== want.last) begin
						err_n++;
						$display("%0t: reply_last: expected %0b, actual %0b",
							$time, want.last, reply_last);
					end
				end
			end

			// unmapped indexes fall through; values are cut to register width
			if (cfg_write === 1'b1) begin
				case (cfg_index)
					REG_STATION_MAC: own_mac   = cfg_data;
					REG_STATION_IP:  own_ip    = cfg_data[31:0];
					REG_ENABLE:      answer_on = cfg_data[0];
					default: ;
				endcase
			end

			if (start === 1'b1 && busy === 1'b0) begin
				if (rx_fill < HdrLen) begin
					rx_hdr[rx_fill] = frame_byte;
					rx_fill++;
				end
				if (frame_end === 1'b1) begin
					if (rx_fill == HdrLen) begin
						to_me  = 1'b1;
						to_all = 1'b1;
						for (i = 0; i < MacBytes; i++) begin
							if (rx_hdr[i] != own_mac_byte(i)) to_me = 1'b0;
							if (rx_hdr[i] != BcastByte) to_all = 1'b0;
						end
						// address length bytes 18 and 19 are deliberately not checked
						hit = answer_on && (to_me || to_all) &&
							rx_hdr[12] == EthTypeHi && rx_hdr[13] == EthTypeLo &&
							rx_hdr[14] == HwTypeHi && rx_hdr[15] == HwTypeLo &&
							rx_hdr[16] == ProtoTypeHi && rx_hdr[17] == ProtoTypeLo &&
							rx_hdr[20] == OpcodeHi && rx_hdr[21] == OpReqLo &&
							own_ip != 32'h0 &&
							{rx_hdr[38], rx_hdr[39], rx_hdr[40], rx_hdr[41]} == own_ip;
						if (hit) begin
							for (i = 0; i < HdrLen; i++) ans[i] = rx_hdr[i];
							for (i = 0; i < MacBytes; i++) begin
								ans[i]            = rx_hdr[MacBytes + i];
								ans[MacBytes + i] = own_mac_byte(i);
								ans[22 + i]       = own_mac_byte(i);
							end
							ans[20] = OpcodeHi;
							ans[21] = OpReplyLo;
							// sender hardware and protocol address become the target
							for (i = 0; i < CheckLen; i++) ans[32 + i] = rx_hdr[22 + i];
							for (i = 0; i < IpBytes; i++) ans[28 + i] = own_ip[31-8*i -: 8];
							for (i = 0; i < HdrLen; i++)
								reply_q.push_back(reply_beat_t'{ans[i], (i == HdrLen - 1)});
						end
					end
					rx_fill = 0;
				end
			end

			awaited         <= reply_q.size();
			mismatches      <= err_n;
			replies_checked <= seen_n;
		end
	end

endmodule

### test/tb_arp_request_responder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_arp_request_responder
// Streams Ethernet frames into the ARP responder: mostly well-formed ARP
// requests with random content, plus corrupted, short, long and junk frames,
// under several station settings. A separate checker predicts and compares
// every reply byte; this module makes the stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_arp_request_responder;
	import arpresp_pkg::*;

	// Unmapped register index; writes to it must change nothing
	localparam logic [CfgIdxW-1:0] REG_UNMAPPED = 2'd3;

	// A matching frame keeps the block busy until its last reply byte is out
	localparam int SettleCycles = 64;
	localparam int CycleLimit   = 600000;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [7:0]          frame_byte;
	logic                frame_end;
	logic                cfg_write;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_data;
	logic                reply_valid;
	logic [7:0]          reply_byte;
	logic                reply_last;

	int fail_count;
	int pending;
	int reply_count;

	// Stimulus-side view of the station, used only to build matching frames
	logic [47:0] cur_mac = '0;
	logic [31:0] cur_ip  = '0;
	logic [7:0]  pkt [$];
	int          bytes_sent    = 0;
	int          frames_sent   = 0;
	int          settings_used = 0;
	int          cycles        = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	arp_request_responder u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.frame_byte  (frame_byte),
		.frame_end   (frame_end),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.reply_valid (reply_valid),
		.reply_byte  (reply_byte),
		.reply_last  (reply_last)
	);

	arp_reply_checker u_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.frame_byte      (frame_byte),
		.frame_end       (frame_end),
		.cfg_write       (cfg_write),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.reply_valid     (reply_valid),
		.reply_byte      (reply_byte),
		.reply_last      (reply_last),
		.mismatches      (fail_count),
		.awaited         (pending),
		.replies_checked (reply_count)
	);

	// Hard stop in case the block hangs or never delivers a reply
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CycleLimit) begin
			$display("arp_request_responder verification failed");
			$finish;
		end
	end

	function automatic logic [47:0] rand48();
		return {16'($urandom), 32'($urandom)};
	endfunction

	function automatic logic [31:0] rand_ip();
		logic [31:0] ip;
		ip = $urandom;
		if (ip == 32'h0) ip = 32'h1;
		return ip;
	endfunction

	// Mostly back-to-back, sometimes a short gap, rarely a long pause
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 70) return 0;
		if (roll < 93) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Drop start for the given gap; scribble on the payload so only start counts
	task automatic idle(input int n);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) begin
				frame_byte <= 8'($urandom);
				frame_end  <= 1'($urandom);
				@(posedge clk);
			end
		end
	endtask

	// Present one byte and hold it until busy is seen low.
	// start is left high so the next byte can follow without a bubble.
	task automatic send_byte(input logic [7:0] b, input logic e);
		start      <= 1'b1;
		frame_byte <= b;
		frame_end  <= e;
		@(posedge clk);
		while (busy !== 1'b0) @(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_frame(input bit steady);
		int i;
		for (i = 0; i < pkt.size(); i++) begin
			if (!steady) idle(pick_gap());
			send_byte(pkt[i], i == pkt.size() - 1);
		end
		frames_sent++;
	endtask

	// Hold off the sender until every predicted reply byte has come back and
	// the block is idle, then optionally wait out any silent reject.
	task automatic drain(input int settle);
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0 || busy !== 1'b0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	// Write all three registers plus the unmapped index in one burst.
	// Upper bits of ip_w and en_w are junk that the block must discard.
	task automatic configure(input logic [47:0] mac_w, input logic [47:0] ip_w,
		input logic [47:0] en_w);
		cfg_write <= 1'b1;
		cfg_index <= REG_STATION_MAC;
		cfg_data  <= mac_w;
		@(posedge clk);
		cfg_index <= REG_STATION_IP;
		cfg_data  <= ip_w;
		@(posedge clk);
		cfg_index <= REG_ENABLE;
		cfg_data  <= en_w;
		@(posedge clk);
		cfg_index <= REG_UNMAPPED;
		cfg_data  <= rand48();
		@(posedge clk);
		cfg_write <= 1'b0;
		cfg_index <= 2'($urandom);
		cfg_data  <= rand48();
		cur_mac = mac_w;
		cur_ip  = ip_w[31:0];
		settings_used++;
	endtask

	// Well-formed ARP request aimed at the station MAC or at broadcast
	task automatic build_request(input bit to_all, input logic [31:0] target);
		int i;
		pkt.delete();
		for (i = 0; i < HdrLen; i++) pkt.push_back(8'($urandom));
		for (i = 0; i < MacBytes; i++) pkt[i] = to_all ? BcastByte : cur_mac[47-8*i -: 8];
		pkt[12] = EthTypeHi;
		pkt[13] = EthTypeLo;
		pkt[14] = HwTypeHi;
		pkt[15] = HwTypeLo;
		pkt[16] = ProtoTypeHi;
		pkt[17] = ProtoTypeLo;
		pkt[18] = 8'(MacBytes);
		pkt[19] = 8'(IpBytes);
		pkt[20] = OpcodeHi;
		pkt[21] = OpReqLo;
		for (i = 0; i < IpBytes; i++) pkt[TpaOffset + i] = target[31-8*i -: 8];
	endtask

	// One random frame: mostly valid requests, the rest broken or noise
	task automatic random_frame();
		int roll, k, n;
		roll = $urandom_range(0, 99);
		build_request($urandom_range(0, 2) == 0, cur_ip);
		if ($urandom_range(0, 4) == 0) begin
			pkt[18] = 8'($urandom);
			pkt[19] = 8'($urandom);
		end
		if (roll < 55) begin
			// leave it well-formed
		end else if (roll < 70) begin
			// flip one bit in one of the checked fields
			case ($urandom_range(0, 5))
				0:       k = $urandom_range(0, MacBytes - 1);
				1:       k = $urandom_range(12, 13);
				2:       k = $urandom_range(14, 15);
				3:       k = $urandom_range(16, 17);
				4:       k = $urandom_range(20, 21);
				default: k = $urandom_range(38, 41);
			endcase
			pkt[k] = pkt[k] ^ (8'h01 << $urandom_range(0, 7));
		end else if (roll < 82) begin
			n = $urandom_range(1, HdrLen - 1);
			while (pkt.size() > n) void'(pkt.pop_back());
		end else if (roll < 92) begin
			n = $urandom_range(1, 20);
			repeat (n) pkt.push_back(8'($urandom));
		end else begin
			n = $urandom_range(1, 60);
			pkt.delete();
			repeat (n) pkt.push_back(8'($urandom));
		end
		// now and then let every outstanding reply come home first
		if ($urandom_range(0, 19) == 0) drain(0);
		send_frame($urandom_range(0, 3) == 0);
		idle(pick_gap());
	endtask

	initial begin : stimulus
		int phase, budget;
		arst_n     <= 1'b0;
		start      <= 1'b0;
		frame_byte <= 8'h00;
		frame_end  <= 1'b0;
		cfg_write  <= 1'b0;
		cfg_index  <= REG_STATION_MAC;
		cfg_data   <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Out of reset the responder is disabled with zero MAC and IP:
		// a request aimed at exactly those must be dropped.
		build_request(1'b0, cur_ip);
		send_frame(1'b1);
		drain(SettleCycles);

		configure(rand48(), {16'($urandom), rand_ip()}, {47'({$urandom, $urandom}), 1'b1});

		// broadcast request of exactly 42 bytes, streamed without gaps
		build_request(1'b1, cur_ip);
		send_frame(1'b1);
		idle(pick_gap());
		// one-byte frame, then a unicast request cut one byte short, with gaps
		pkt = {8'($urandom)};
		send_frame(1'b1);
		build_request(1'b0, cur_ip);
		void'(pkt.pop_back());
		send_frame(1'b0);
		// long unicast frame with gaps inside: trailing bytes are ignored,
		// the check still fires at the end
		build_request(1'b0, cur_ip);
		repeat (10) pkt.push_back(8'($urandom));
		send_frame(1'b0);
		// immediately behind it, so the byte count must have restarted;
		// odd address length bytes do not matter
		build_request(1'b1, cur_ip);
		pkt[18] = 8'hff;
		pkt[19] = 8'h00;
		send_frame(1'b1);

		// Random part: one station setting per phase, drained in between
		for (phase = 0; phase < 5; phase++) begin
			drain(SettleCycles);
			case (phase)
				0: begin
					configure(rand48(), {16'($urandom), rand_ip()}, 48'h1);
					budget = 30;
				end
				1: begin
					// all-ones MAC and IP: station MAC equals broadcast
					configure(48'hffff_ffff_ffff, 48'hffff_ffff_ffff, 48'h1);
					budget = 20;
				end
				2: begin
					configure(rand48(), {16'($urandom), rand_ip()}, 48'h0);
					budget = 10;
				end
				3: begin
					configure(48'h0, 48'h1, {47'({$urandom, $urandom}), 1'b1});
					budget = 20;
				end
				default: begin
					// zero station IP disables replies even when enabled
					configure(rand48(), 48'h0, 48'h1);
					budget = 10;
				end
			endcase
			budget = budget + bytes_sent;
			while (bytes_sent < budget) random_frame();
		end

		// wait for the last reply, then let the block sit for a while
		drain(SettleCycles);

		$display("Sent %0d frames (%0d bytes) under %0d station settings.",
			frames_sent, bytes_sent, settings_used);
		$display("Compared %0d reply bytes against predicted ARP replies.", reply_count);
		if (fail_count == 0 && pending == 0) begin
			$display("arp_request_responder verification clean");
		end else begin
			$display("arp_request_responder verification failed");
		end
		$finish;
	end

endmodule

### sim.f
rtl/core/arpresp_pkg.sv
rtl/core/arpresp_ram.sv
rtl/core/arp_request_responder.sv
test/arp_reply_checker.sv
test/tb_arp_request_responder.sv
